@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/i8dq_pkg.sv @@
// ----------------------------------------------------------------------------
// i8dq_pkg
// Types, constants and float helpers for the int8 block dequantiser.
// ----------------------------------------------------------------------------
package i8dq_pkg;

    localparam int BlockElements = 32;

    localparam logic [1:0] FMT_BLOCK  = 2'd0;
    localparam logic [1:0] FMT_HALF   = 2'd1;
    localparam logic [1:0] FMT_SINGLE = 2'd2;

    localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;

    // Item handed from the front (position) stage to the arithmetic stage.
    typedef struct packed {
        logic [1:0]  kind;      // which conversion to apply
        logic [15:0] half;      // half word (scale or value)
        logic [7:0]  qbyte;     // signed element for block mode
        logic [31:0] word;      // single passthrough word
        logic        last;
    } i8dq_item_t;

    localparam logic [1:0] KIND_BLOCK  = 2'd0;
    localparam logic [1:0] KIND_HALF   = 2'd1;
    localparam logic [1:0] KIND_SINGLE = 2'd2;

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        s;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  lz;
        logic [10:0] sh;
        logic [7:0]  e;
        s   = h[15];
        ex  = h[14:10];
        man = h[9:0];
        lz  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) lz = 4'(9 - i);
        end
        sh = {1'b0, man} << (lz + 4'd1);
        e  = 8'(8'd112 - {4'd0, lz});
        if (ex == 5'd0) begin
            if (man == 10'd0) widen_half = {s, 31'd0};
            else              widen_half = {s, e, sh[9:0], 13'd0};
        end else if (ex == 5'h1F) begin
            widen_half = {s, 8'hFF, man, 13'd0};
        end else begin
            widen_half = {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
    endfunction

endpackage

@@ hw/rtl/int8_block_dequantizer_top.sv @@
// ----------------------------------------------------------------------------
// int8_block_dequantizer_top
// Byte stream to fp32 dequantiser: int8 blocks, half or single words.
// ----------------------------------------------------------------------------
//  channel  | ports                              | direction
//  s_       | s_valid s_ready s_data_byte s_start_req | in, one byte a beat
//  m_       | m_valid m_ready m_value m_block_last    | out, one fp32 a beat
//  cfg      | cfg_we cfg_wdata                   | format register write
//
// One beat in per cycle while s_ready is high; a result leaves in the cycle after the byte that
// completes it, through a single output register.
// s_ready is high whenever the output register is empty or being drained.
// Reset clears byte position, scale, pending bytes and format (block mode).
// A stalled m_ side holds its beat and stalls s_ only while it is full.
module int8_block_dequantizer_top #(
    parameter int BLOCK_ELEMENTS = i8dq_pkg::BlockElements
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_value,
    output logic        m_block_last
);
    import i8dq_pkg::*;
    `include "assert_macros.svh"

    logic [1:0]  format_reg;
    logic        take, item_valid;
    i8dq_item_t  item;
    logic [31:0] value;
    logic        m_valid_reg;
    logic [31:0] m_value_reg;
    logic        m_last_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) format_reg <= FMT_BLOCK;
        else if (cfg_we) format_reg <= cfg_wdata;
    end

    i8dq_front #(
        .BLOCK_ELEMENTS (BLOCK_ELEMENTS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .format     (format_reg),
        .take       (take),
        .data_byte  (s_data_byte),
        .start_req  (s_start_req),
        .item_valid (item_valid),
        .item       (item)
    );

    i8dq_arith u_arith (
        .item  (item),
        .value (value)
    );

    // Load on a producing beat, drop once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= take && item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && item_valid) begin
            m_value_reg <= value;
            m_last_reg  <= item.last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_block_last = m_valid_reg && m_last_reg;

    `ASSERT_IMPL(a_stall_blocks, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `ASSERT_NEXT(a_hold_value, aclk, aresetn, m_valid && !m_ready, $stable(m_value))
    `ASSERT_NEXT(a_emit, aclk, aresetn, take && item_valid, m_valid)
endmodule

@@ hw/rtl/i8dq_front.sv @@
// ----------------------------------------------------------------------------
// i8dq_front
// Byte position tracking and word assembly; emits one item per element.
// ----------------------------------------------------------------------------
module i8dq_front #(
    parameter int BLOCK_ELEMENTS = i8dq_pkg::BlockElements
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            format,
    input  logic                  take,
    input  logic [7:0]            data_byte,
    input  logic                  start_req,
    output logic                  item_valid,
    output i8dq_pkg::i8dq_item_t  item
);
    import i8dq_pkg::*;

    localparam logic [5:0] LastPos = 6'(BLOCK_ELEMENTS + 1);

    logic [5:0]  pos_reg, pos_next, pos;
    logic [15:0] scale_reg, scale_next;
    logic [23:0] pend_reg, pend_next;

    always_comb begin
        pos        = start_req ? 6'd0 : pos_reg;
        pos_next   = pos_reg;
        scale_next = scale_reg;
        pend_next  = pend_reg;
        item_valid = 1'b0;
        item       = '0;
        case (format)
            FMT_BLOCK: begin
                if (pos > LastPos) pos = 6'd0;
                if (pos == 6'd0) begin
                    scale_next = {scale_reg[15:8], data_byte};
                    pos_next   = 6'd1;
                end else if (pos == 6'd1) begin
                    scale_next = {data_byte, scale_reg[7:0]};
                    pos_next   = 6'd2;
                end else begin
                    item_valid = 1'b1;
                    item.kind  = KIND_BLOCK;
                    item.half  = scale_reg;
                    item.qbyte = data_byte;
                    item.last  = (pos == LastPos);
                    pos_next   = (pos == LastPos) ? 6'd0 : pos + 6'd1;
                end
            end
            FMT_HALF: begin
                if (pos > 6'd1) pos = 6'd0;
                if (pos == 6'd0) begin
                    pend_next = {pend_reg[23:8], data_byte};
                    pos_next  = 6'd1;
                end else begin
                    item_valid = 1'b1;
                    item.kind  = KIND_HALF;
                    item.half  = {data_byte, pend_reg[7:0]};
                    pos_next   = 6'd0;
                end
            end
            FMT_SINGLE: begin
                if (pos > 6'd3) pos = 6'd0;
                if (pos == 6'd3) begin
                    item_valid = 1'b1;
                    item.kind  = KIND_SINGLE;
                    item.word  = {data_byte, pend_reg};
                    pos_next   = 6'd0;
                end else begin
                    case (pos[1:0])
                        2'd0:    pend_next = {pend_reg[23:8], data_byte};
                        2'd1:    pend_next = {pend_reg[23:16], data_byte, pend_reg[7:0]};
                        default: pend_next = {data_byte, pend_reg[15:0]};
                    endcase
                    pos_next = pos + 6'd1;
                end
            end
            default: begin
                pos_next = pos;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            scale_reg <= '0;
            pend_reg  <= '0;
        end else if (take) begin
            pos_reg   <= pos_next;
            scale_reg <= scale_next;
            pend_reg  <= pend_next;
        end
    end
endmodule

@@ hw/rtl/i8dq_arith.sv @@
// ----------------------------------------------------------------------------
// i8dq_arith
// Scale widening, exact 24x8 product and normalisation.
// ----------------------------------------------------------------------------
module i8dq_arith (
    input  i8dq_pkg::i8dq_item_t  item,
    output logic [31:0]           value
);
    import i8dq_pkg::*;

    logic [31:0] f;
    logic        qneg, sgn;
    logic [7:0]  mag, ex;
    logic [31:0] prod;
    logic [2:0]  sh;
    logic [31:0] pshift;

    always_comb begin
        f     = widen_half(item.half);
        ex    = f[30:23];
        qneg  = item.qbyte[7];
        mag   = qneg ? 8'(-item.qbyte) : item.qbyte;
        sgn   = f[31] ^ qneg;
        prod  = {8'd0, 1'b1, f[22:0]} * {24'd0, mag};
        sh    = 3'd0;
        for (int i = 24; i < 32; i++) begin
            if (prod[i]) sh = 3'(i - 23);
        end
        pshift = prod >> sh;
        case (item.kind)
            KIND_HALF:   value = f;
            KIND_SINGLE: value = item.word;
            default: begin
                if (ex == 8'hFF) begin
                    if (f[22:0] != 23'd0)      value = f | 32'h0040_0000;
                    else if (item.qbyte == 0)  value = QNAN_DEFAULT;
                    else                       value = {sgn, 31'h7F80_0000};
                end else if (ex == 8'd0 || item.qbyte == 8'd0) begin
                    value = {sgn, 31'd0};
                end else begin
                    value = {sgn, 8'(ex + {5'd0, sh}), pshift[22:0]};
                end
            end
        endcase
    end
endmodule
